/* rtl/core/qau_pkg.sv */
// Shared types, command codes and Hamilton product tables of the quaternion arithmetic unit.
package qau_pkg;

  parameter int COMPONENT_WIDTH = 32;
  parameter int FRACTION_BITS   = 16;
  parameter int CMD_WIDTH       = 3;

  typedef enum logic [CMD_WIDTH-1:0] {
    CMD_ADD  = 3'd0,
    CMD_SUB  = 3'd1,
    CMD_MUL  = 3'd2,
    CMD_CONJ = 3'd3,
    CMD_ROT  = 3'd4
  } cmd_e;

  // For result component c, term k multiplies A[k] by B[HAM_B_IDX[c][k]].
  parameter logic [1:0] HAM_B_IDX [4][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd2, 2'd3, 2'd0, 2'd1},
    '{2'd3, 2'd2, 2'd1, 2'd0}
  };

  // A set bit subtracts that term from the sum.
  parameter logic HAM_NEG [4][4] = '{
    '{1'b0, 1'b1, 1'b1, 1'b1},
    '{1'b0, 1'b0, 1'b0, 1'b1},
    '{1'b0, 1'b1, 1'b0, 1'b0},
    '{1'b0, 1'b0, 1'b1, 1'b0}
  };

endpackage

/* rtl/core/quaternion_arithmetic_unit.sv */
// Pipelined quaternion add, subtract, Hamilton product, conjugate and rotation unit.
// Throughput is one item per cycle unless the output stalls, set by the two rows of sixteen multipliers.
// Each stage advances when its successor is empty or advancing, so a stall loses nothing.
// Reset clears the stage valid bits only; payload registers are not reset.
module quaternion_arithmetic_unit #(
  parameter int COMPONENT_WIDTH = qau_pkg::COMPONENT_WIDTH,
  parameter int FRACTION_BITS   = qau_pkg::FRACTION_BITS
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        s_axis_tvalid,
  output logic                                        s_axis_tready,
  // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z from the lowest bit up.
  input  logic [8*COMPONENT_WIDTH-1:0]                s_axis_tdata,
  // command.
  input  logic [qau_pkg::CMD_WIDTH-1:0]               s_axis_tuser,
  output logic                                        m_axis_tvalid,
  input  logic                                        m_axis_tready,
  // r_w, r_x, r_y, r_z from the lowest bit up, then zero fill.
  output logic [((4*COMPONENT_WIDTH+7)/8)*8-1:0]      m_axis_tdata,
  // saturated.
  output logic                                        m_axis_tuser
);

  localparam int W        = COMPONENT_WIDTH;
  localparam int W1       = W + 1;
  localparam int W2       = W + 2;
  localparam int F        = FRACTION_BITS;
  localparam int PW       = 2 * W;
  localparam int NST      = 7;
  localparam int OUT_BITS = ((4 * W + 7) / 8) * 8;

  localparam logic [W-1:0]  MAX_VAL = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  MIN_VAL = {1'b1, {(W-1){1'b0}}};
  localparam logic [PW-1:0] HALF    = PW'(1) << (F - 1);

  typedef logic [W-1:0]  comp_t;
  typedef comp_t [3:0]   quat_t;
  typedef logic [PW-1:0] wide_t;
  typedef wide_t [3:0]   wrow_t;
  typedef wrow_t [3:0]   prods_t;
  typedef quat_t [3:0]   rnds_t;

  function automatic logic [W:0] sat_w(input logic [PW-1:0] v);
    logic pos_ovf;
    logic neg_ovf;
    pos_ovf = !v[PW-1] && (|v[PW-2:W-1]);
    neg_ovf = v[PW-1] && !(&v[PW-2:W-1]);
    if (pos_ovf) begin
      sat_w = {1'b1, MAX_VAL};
    end else if (neg_ovf) begin
      sat_w = {1'b1, MIN_VAL};
    end else begin
      sat_w = {1'b0, v[W-1:0]};
    end
  endfunction

  function automatic logic [W:0] rnd_sat(input logic [PW-1:0] p);
    logic signed [PW-1:0] s;
    s = ($signed(p) + $signed(HALF)) >>> F;
    rnd_sat = sat_w(s);
  endfunction

  function automatic logic [W:0] dot_sat(input quat_t q, input logic [1:0] row);
    logic signed [W2-1:0] acc;
    acc = '0;
    for (int k = 0; k < 4; k++) begin
      if (qau_pkg::HAM_NEG[row][k]) begin
        acc = acc - W2'($signed(q[k]));
      end else begin
        acc = acc + W2'($signed(q[k]));
      end
    end
    dot_sat = sat_w(PW'(acc));
  endfunction

  logic [NST-1:0] vld_q, vld_d, adv;

  qau_pkg::cmd_e cmd1_d, cmd1_q, cmd2_q, cmd3_q, cmd4_q, cmd5_q, cmd6_q;
  quat_t  a1_d, a1_q, b1_d, b1_q;
  prods_t prod2_d, prod2_q;
  quat_t  cj2_d, cj2_q, cj3_q, cj4_q;
  quat_t  dir2_d, dir2_q, dir3_q, dir4_q, dir5_q, dir6_q;
  logic   flg2_d, flg2_q, flg3_d, flg3_q, flg4_d, flg4_q, flg5_q, flg6_d, flg6_q;
  rnds_t  rnd3_d, rnd3_q;
  quat_t  t4_d, t4_q, t5_q, t6_q;
  prods_t prod5_d, prod5_q;
  rnds_t  rnd6_d, rnd6_q;
  quat_t  r7_d, r7_q;
  logic   flg7_d, flg7_q;

  always_comb begin
    adv[NST-1] = !vld_q[NST-1] || m_axis_tready;
    for (int k = NST - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
    vld_d = vld_q;
    if (adv[0]) begin
      vld_d[0] = s_axis_tvalid;
    end
    for (int k = 1; k < NST; k++) begin
      if (adv[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_axis_tready = adv[0];

  always_comb begin
    cmd1_d = qau_pkg::cmd_e'(s_axis_tuser);
    for (int c = 0; c < 4; c++) begin
      a1_d[c] = s_axis_tdata[c*W +: W];
      b1_d[c] = s_axis_tdata[(4+c)*W +: W];
    end
  end

  always_comb begin
    logic signed [W:0] tmp;
    logic [W:0]        sr;
    logic              cflg;
    logic              aflg;
    quat_t             sum;
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        prod2_d[c][k] = PW'($signed(a1_q[k])) *
                        PW'($signed(b1_q[qau_pkg::HAM_B_IDX[c][k]]));
      end
    end
    cflg     = 1'b0;
    cj2_d[0] = a1_q[0];
    for (int c = 1; c < 4; c++) begin
      tmp      = -W1'($signed(a1_q[c]));
      sr       = sat_w(PW'(tmp));
      cj2_d[c] = sr[W-1:0];
      cflg     = cflg | sr[W];
    end
    aflg = 1'b0;
    for (int c = 0; c < 4; c++) begin
      if (cmd1_q == qau_pkg::CMD_SUB) begin
        tmp = W1'($signed(a1_q[c])) - W1'($signed(b1_q[c]));
      end else begin
        tmp = W1'($signed(a1_q[c])) + W1'($signed(b1_q[c]));
      end
      sr     = sat_w(PW'(tmp));
      sum[c] = sr[W-1:0];
      aflg   = aflg | sr[W];
    end
    unique case (cmd1_q) inside
      qau_pkg::CMD_ADD, qau_pkg::CMD_SUB: begin
        dir2_d = sum;
        flg2_d = aflg;
      end
      qau_pkg::CMD_CONJ: begin
        dir2_d = cj2_d;
        flg2_d = cflg;
      end
      qau_pkg::CMD_ROT: begin
        dir2_d = '0;
        flg2_d = cflg;
      end
      default: begin
        dir2_d = '0;
        flg2_d = 1'b0;
      end
    endcase
  end

  always_comb begin
    logic [W:0] rr;
    logic       any;
    any = 1'b0;
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        rr            = rnd_sat(prod2_q[c][k]);
        rnd3_d[c][k]  = rr[W-1:0];
        any           = any | rr[W];
      end
    end
    flg3_d = flg2_q | (any && (cmd2_q == qau_pkg::CMD_MUL || cmd2_q == qau_pkg::CMD_ROT));
  end

  always_comb begin
    logic [W:0] dr;
    logic       any;
    any = 1'b0;
    for (int c = 0; c < 4; c++) begin
      dr      = dot_sat(rnd3_q[c], 2'(c));
      t4_d[c] = dr[W-1:0];
      any     = any | dr[W];
    end
    flg4_d = flg3_q | (any && (cmd3_q == qau_pkg::CMD_MUL || cmd3_q == qau_pkg::CMD_ROT));
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        prod5_d[c][k] = PW'($signed(t4_q[k])) *
                        PW'($signed(cj4_q[qau_pkg::HAM_B_IDX[c][k]]));
      end
    end
  end

  always_comb begin
    logic [W:0] rr;
    logic       any;
    any = 1'b0;
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        rr           = rnd_sat(prod5_q[c][k]);
        rnd6_d[c][k] = rr[W-1:0];
        any          = any | rr[W];
      end
    end
    flg6_d = flg5_q | (any && (cmd5_q == qau_pkg::CMD_ROT));
  end

  always_comb begin
    logic [W:0] dr;
    logic       any;
    quat_t      rot;
    any = 1'b0;
    for (int c = 0; c < 4; c++) begin
      dr     = dot_sat(rnd6_q[c], 2'(c));
      rot[c] = dr[W-1:0];
      any    = any | dr[W];
    end
    flg7_d = flg6_q;
    case (cmd6_q) inside
      qau_pkg::CMD_ADD, qau_pkg::CMD_SUB, qau_pkg::CMD_CONJ: r7_d = dir6_q;
      qau_pkg::CMD_MUL: r7_d = t6_q;
      qau_pkg::CMD_ROT: begin
        r7_d   = rot;
        flg7_d = flg6_q | any;
      end
      default: r7_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      cmd1_q <= cmd1_d;
      a1_q   <= a1_d;
      b1_q   <= b1_d;
    end
    if (adv[1]) begin
      cmd2_q  <= cmd1_q;
      prod2_q <= prod2_d;
      cj2_q   <= cj2_d;
      dir2_q  <= dir2_d;
      flg2_q  <= flg2_d;
    end
    if (adv[2]) begin
      cmd3_q <= cmd2_q;
      rnd3_q <= rnd3_d;
      cj3_q  <= cj2_q;
      dir3_q <= dir2_q;
      flg3_q <= flg3_d;
    end
    if (adv[3]) begin
      cmd4_q <= cmd3_q;
      t4_q   <= t4_d;
      cj4_q  <= cj3_q;
      dir4_q <= dir3_q;
      flg4_q <= flg4_d;
    end
    if (adv[4]) begin
      cmd5_q  <= cmd4_q;
      prod5_q <= prod5_d;
      t5_q    <= t4_q;
      dir5_q  <= dir4_q;
      flg5_q  <= flg4_q;
    end
    if (adv[5]) begin
      cmd6_q <= cmd5_q;
      rnd6_q <= rnd6_d;
      t6_q   <= t5_q;
      dir6_q <= dir5_q;
      flg6_q <= flg6_d;
    end
    if (adv[6]) begin
      r7_q   <= r7_d;
      flg7_q <= flg7_d;
    end
  end

  assign m_axis_tvalid = vld_q[NST-1];
  assign m_axis_tdata  = OUT_BITS'(r7_q);
  assign m_axis_tuser  = flg7_q;

endmodule
